// ===== rtl/msqrt_pkg.sv =====
// shared constants and types for the modular square root block
package msqrt_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int NR_LIMIT  = 4096;
    localparam int IN_W      = 32;
    localparam int ROOT_W    = 32;
    localparam int STAT_W    = 2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONRES  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_MOD = 2'd2;

endpackage

// ===== rtl/msqrt_if.sv =====
// valid/ready channel interfaces for requests and results
interface msqrt_req_if;
    import msqrt_pkg::*;
    logic              valid;
    logic              ready;
    logic [IN_W-1:0]   modulus;
    logic [IN_W-1:0]   value;
    modport source (output valid, output modulus, output value, input ready);
    modport sink   (input valid, input modulus, input value, output ready);
endinterface

interface msqrt_res_if;
    import msqrt_pkg::*;
    logic                valid;
    logic                ready;
    logic [ROOT_W-1:0]   root;
    logic [STAT_W-1:0]   status;
    modport source (output valid, output root, output status, input ready);
    modport sink   (input valid, input root, input status, output ready);
endinterface

// ===== rtl/msqrt_mulmod.sv =====
// bit-serial modular multiplier: one double-and-add step per cycle
module msqrt_mulmod
    import msqrt_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_prod
);

    logic             r_busy;
    logic [WIDTH-1:0] r_a, r_b, r_acc, r_m;
    logic [WIDTH-1:0] n_acc, n_a;

    // modular add of two operands below m
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] d;
        d = m - y;
        if (x >= d) return x - d;
        return x + y;
    endfunction

    // one step of the shift-add loop
    always_comb begin
        n_acc = r_b[0] ? add_mod(r_acc, r_a, r_m) : r_acc;
        n_a   = add_mod(r_a, r_a, r_m);
    end

    // operands are already reduced by the caller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_b    <= i_b;
                r_m    <= i_m;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_b == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_acc <= n_acc;
                    r_a   <= n_a;
                    r_b   <= r_b >> 1;
                end
            end
        end
    end

    assign o_prod = r_acc;

endmodule

// ===== rtl/modular_square_root.sv =====
// top level: Tonelli-Shanks modular square root sequencer
// One request at a time: ready is high only while the sequencer is idle. All
// arithmetic runs on one shared bit-serial modular multiplier, one product at a
// time. A request first reduces the value mod p bit by bit, then runs an Euler
// check, a non-residue search with one exponentiation per candidate (up to 4096
// candidates), three more exponentiations and a refinement loop of up to about
// s*s/2 squarings, where p-1 = q*2^s. A bad modulus is answered without the
// reduction and a zero value right after it. The result sits in an output
// register until taken, and the next request may be accepted while it waits;
// that request holds in its last step until the register is free.
module modular_square_root
    import msqrt_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msqrt_req_if.sink   i_req,
    msqrt_res_if.source o_res
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam int ZW = $clog2(NR_LIMIT + 1);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_RED    = 15'b000000000000010,
        S_CHK    = 15'b000000000000100,
        S_SPLIT  = 15'b000000000001000,
        S_ZTRY   = 15'b000000000010000,
        S_ZCHK   = 15'b000000000100000,
        S_PREP   = 15'b000000001000000,
        S_LOOP   = 15'b000000010000000,
        S_TSQ    = 15'b000000100000000,
        S_BSQ    = 15'b000001000000000,
        S_UPD    = 15'b000010000000000,
        S_FIN    = 15'b000100000000000,
        S_POW    = 15'b001000000000000,
        S_MUL    = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } t_state;

    // which operation the shared unit serves after an exponentiation/product
    typedef enum logic [3:0] {
        P_EULER, P_ZEUL, P_C, P_R, P_A, P_TSQ, P_BSQ, P_UR, P_UC, P_UA, P_FIN
    } t_ret;

    t_state           r_st;
    t_ret             r_ret;
    logic [WIDTH-1:0] r_p, r_n, r_q, r_half, r_z, r_c, r_r, r_a, r_b, r_t;
    logic [WIDTH-1:0] r_base, r_exp, r_acc, r_rem;
    logic [CW-1:0]    r_s, r_m, r_i, r_k;
    logic [ZW-1:0]    r_zc;
    logic [WIDTH-1:0] r_rbit;
    logic [ROOT_W-1:0] r_root;
    logic [STAT_W-1:0] r_stat;
    logic [ROOT_W-1:0] r_out_root;
    logic [STAT_W-1:0] r_out_stat;
    logic             r_valid, r_pstep;

    logic             mm_start, mm_done;
    logic [WIDTH-1:0] mm_a, mm_b, mm_prod;
    logic [WIDTH-1:0] p_in, n_in, rem_sh;
    logic [WIDTH:0]   rem_try;
    logic             tsq_go, bsq_end;

    msqrt_mulmod #(.WIDTH(WIDTH)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mm_start),
        .i_a(mm_a), .i_b(mm_b), .i_m(r_p), .o_done(mm_done), .o_prod(mm_prod)
    );

    // inputs cut to the working width, and the restoring-reduction step
    always_comb begin
        p_in = WIDTH'(i_req.modulus);
        n_in = WIDTH'(i_req.value);
        rem_try = {r_rem, r_rbit[WIDTH-1]} ;
        rem_sh  = (rem_try >= {1'b0, r_p}) ? WIDTH'(rem_try - {1'b0, r_p})
                                            : WIDTH'(rem_try);
    end

    // loop tests of the refinement step
    assign tsq_go  = (r_i < r_m) && (r_t != WIDTH'(1));
    assign bsq_end = (r_k + r_i + CW'(1)) >= r_m;

    assign i_req.ready  = (r_st == S_IDLE);
    assign o_res.valid  = r_valid;
    assign o_res.root   = r_out_root;
    assign o_res.status = r_out_stat;

    // operand selection for the shared multiplier
    always_comb begin
        mm_start = 1'b0;
        mm_a = r_acc;
        mm_b = r_base;
        if (r_st == S_POW && r_exp != '0 && !r_pstep) begin
            mm_start = 1'b1;
            if (r_exp[0]) begin
                mm_a = r_acc; mm_b = r_base;
            end else begin
                mm_a = r_base; mm_b = r_base;
            end
        end else if (r_st == S_TSQ) begin
            mm_start = !r_pstep && tsq_go;
            mm_a = r_t; mm_b = r_t;
        end else if (r_st == S_BSQ) begin
            mm_start = !r_pstep && !bsq_end;
            mm_a = r_b; mm_b = r_b;
        end else if (r_st == S_MUL) begin
            mm_start = !r_pstep;
            mm_a = r_acc; mm_b = r_base;
        end
    end

    // output register, reloaded as soon as the previous result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (r_st == S_OUT && (!r_valid || o_res.ready)) begin
            r_valid    <= 1'b1;
            r_out_root <= r_root;
            r_out_stat <= r_stat;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_pstep <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_p <= p_in;
                        r_rbit <= n_in;
                        r_rem <= '0;
                        r_i <= '0;
                        if (p_in < WIDTH'(3) || !p_in[0]) begin
                            r_root <= '0; r_stat <= ST_BAD_MOD; r_st <= S_OUT;
                        end else begin
                            r_st <= S_RED;
                        end
                    end
                end
                // restoring reduction of n mod p, one bit per cycle
                S_RED: begin
                    r_rem  <= rem_sh;
                    r_rbit <= r_rbit << 1;
                    r_i    <= r_i + 1'b1;
                    if (r_i == CW'(WIDTH - 1)) r_st <= S_CHK;
                end
                S_CHK: begin
                    r_n    <= r_rem;
                    r_half <= (r_p - 1'b1) >> 1;
                    if (r_rem == '0) begin
                        r_root <= '0; r_stat <= ST_OK; r_st <= S_OUT;
                    end else begin
                        r_base <= r_rem; r_exp <= (r_p - 1'b1) >> 1;
                        r_acc <= WIDTH'(1); r_pstep <= 1'b0;
                        r_ret <= P_EULER; r_st <= S_POW;
                        r_q <= r_p - 1'b1; r_s <= '0;
                    end
                end
                S_SPLIT: begin
                    if (!r_q[0]) begin
                        r_q <= r_q >> 1; r_s <= r_s + 1'b1;
                    end else begin
                        r_z <= '0; r_zc <= '0; r_st <= S_ZTRY;
                    end
                end
                S_ZTRY: begin
                    if (r_zc == ZW'(NR_LIMIT) || r_z >= r_p) begin
                        r_root <= '0; r_stat <= ST_NONRES; r_st <= S_OUT;
                    end else begin
                        r_base <= r_z; r_exp <= r_half; r_acc <= WIDTH'(1);
                        r_pstep <= 1'b0; r_ret <= P_ZEUL; r_st <= S_POW;
                    end
                end
                S_ZCHK: begin
                    if (r_acc == r_p - 1'b1) begin
                        r_base <= r_z; r_exp <= r_q; r_acc <= WIDTH'(1);
                        r_pstep <= 1'b0; r_ret <= P_C; r_st <= S_POW;
                    end else begin
                        r_z <= r_z + 1'b1; r_zc <= r_zc + 1'b1; r_st <= S_ZTRY;
                    end
                end
                S_PREP: begin
                    r_m <= r_s; r_st <= S_LOOP;
                end
                S_LOOP: begin
                    if (r_a == WIDTH'(1)) begin
                        r_acc <= r_r; r_base <= r_r; r_ret <= P_FIN; r_st <= S_MUL;
                    end else begin
                        r_t <= r_a; r_i <= '0; r_st <= S_TSQ; r_pstep <= 1'b0;
                    end
                end
                // find least i with a^(2^i) == 1
                S_TSQ: begin
                    if (!r_pstep) begin
                        if (r_i >= r_m) begin
                            r_root <= '0; r_stat <= ST_NONRES; r_st <= S_OUT;
                        end else if (r_t == WIDTH'(1)) begin
                            r_b <= r_c; r_k <= '0; r_st <= S_BSQ;
                        end else begin
                            r_pstep <= 1'b1;
                        end
                    end else if (mm_done) begin
                        r_t <= mm_prod; r_i <= r_i + 1'b1; r_pstep <= 1'b0;
                    end
                end
                S_BSQ: begin
                    if (!r_pstep) begin
                        if (bsq_end) begin
                            r_acc <= r_r; r_base <= r_b; r_ret <= P_UR; r_st <= S_MUL;
                        end else begin
                            r_pstep <= 1'b1;
                        end
                    end else if (mm_done) begin
                        r_b <= mm_prod; r_k <= r_k + 1'b1; r_pstep <= 1'b0;
                    end
                end
                S_UPD: begin
                    r_m <= r_i; r_st <= S_LOOP;
                end
                // products through the shared unit, one at a time; the update runs r, c and a in turn
                S_MUL: begin
                    if (!r_pstep) begin
                        r_pstep <= 1'b1;
                    end else if (mm_done) begin
                        r_pstep <= 1'b0;
                        case (r_ret)
                            P_UR: begin
                                r_r <= mm_prod; r_acc <= r_b; r_base <= r_b;
                                r_ret <= P_UC;
                            end
                            P_UC: begin
                                r_c <= mm_prod; r_acc <= r_a; r_base <= mm_prod;
                                r_ret <= P_UA;
                            end
                            P_UA: begin
                                r_a <= mm_prod; r_st <= S_UPD;
                            end
                            default: begin
                                r_st <= S_FIN; r_acc <= mm_prod;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    if (r_acc == r_n) begin
                        r_root <= ROOT_W'(r_r); r_stat <= ST_OK;
                    end else begin
                        r_root <= '0; r_stat <= ST_NONRES;
                    end
                    r_st <= S_OUT;
                end
                // square-and-multiply, one product at a time
                S_POW: begin
                    if (r_exp == '0) begin
                        case (r_ret)
                            P_EULER: begin
                                if (r_acc != WIDTH'(1)) begin
                                    r_root <= '0; r_stat <= ST_NONRES; r_st <= S_OUT;
                                end else begin
                                    r_st <= S_SPLIT;
                                end
                            end
                            P_ZEUL: r_st <= S_ZCHK;
                            P_C: begin
                                r_c <= r_acc; r_base <= r_n;
                                r_exp <= (r_q >> 1) + 1'b1;
                                r_acc <= WIDTH'(1); r_ret <= P_R;
                            end
                            P_R: begin
                                r_r <= r_acc; r_base <= r_n; r_exp <= r_q;
                                r_acc <= WIDTH'(1); r_ret <= P_A;
                            end
                            default: begin
                                r_a <= r_acc; r_st <= S_PREP;
                            end
                        endcase
                    end else if (!r_pstep) begin
                        r_pstep <= 1'b1;
                    end else if (mm_done) begin
                        if (r_exp[0]) begin
                            r_acc <= mm_prod;
                            r_exp[0] <= 1'b0;
                            r_pstep <= 1'b0;
                        end else begin
                            r_base <= mm_prod;
                            r_exp <= r_exp >> 1;
                            r_pstep <= 1'b0;
                        end
                    end
                end
                // hand over once the output register is free
                S_OUT: begin
                    if (!r_valid || o_res.ready) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// testbench for the modular square root block: directed and random requests
module tb_top;
    import msqrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [STAT_W-1:0] status;
    } sqrt_result_t;

    logic i_clk;
    logic i_rst_n;

    msqrt_req_if req_if ();
    msqrt_res_if res_if ();

    modular_square_root dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    sqrt_result_t pending_roots[$];
    int           mismatch_cnt;
    int           sent_cnt;
    int           checked_cnt;
    bit           idle_en;
    bit           hold_req;
    int           hold_left;

    // large primes, several with a deep power of two in p-1
    logic [IN_W-1:0] big_primes[6] = '{32'd4294967291, 32'd2147483647, 32'd1000000007,
                                       32'd998244353, 32'd3221225473, 32'd2013265921};

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000000;
        $display("FAIL modular_square_root");
        $finish;
    end

    // modular arithmetic for the predictor, operands below 2^32
    function automatic logic [63:0] mul_m(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] p);
        mul_m = ((a % p) * (b % p)) % p;
    endfunction

    function automatic logic [63:0] pow_m(input logic [63:0] base, input logic [63:0] e,
                                          input logic [63:0] p);
        logic [63:0] acc;
        logic [63:0] b;
        logic [63:0] x;
        acc = 64'd1 % p;
        b = base % p;
        x = e;
        while (x != 0) begin
            if (x[0]) acc = mul_m(acc, b, p);
            b = mul_m(b, b, p);
            x = x >> 1;
        end
        pow_m = acc;
    endfunction

    // tonelli-shanks root with status
    function automatic sqrt_result_t predict_root(input logic [IN_W-1:0] modulus,
                                                  input logic [IN_W-1:0] value);
        logic [63:0] p, n, q, z, c, r, a, b, half, t;
        int s, m, i, k;
        bit found;
        sqrt_result_t res;
        res = '{root: '0, status: ST_OK};
        p = modulus;
        n = value;
        if (p < 3 || p[0] == 1'b0) begin
            res.status = ST_BAD_MOD;
            return res;
        end
        n = n % p;
        if (n == 0) return res;
        half = (p - 1) >> 1;
        if (pow_m(n, half, p) != 1) begin
            res.status = ST_NONRES;
            return res;
        end
        q = p - 1;
        s = 0;
        while (q[0] == 1'b0) begin
            q = q >> 1;
            s++;
        end
        found = 0;
        z = 0;
        while (z < NR_LIMIT && z < p) begin
            if (pow_m(z, half, p) == p - 1) begin
                found = 1;
                break;
            end
            z++;
        end
        if (!found) begin
            res.status = ST_NONRES;
            return res;
        end
        c = pow_m(z, q, p);
        r = pow_m(n, (q >> 1) + 1, p);
        a = pow_m(n, q, p);
        m = s;
        while (a != 1) begin
            t = a;
            for (i = 0; i < m; i++) begin
                if (t == 1) break;
                t = mul_m(t, t, p);
            end
            if (i >= m) begin
                res.status = ST_NONRES;
                return res;
            end
            b = c;
            for (k = 0; k + i + 1 < m; k++) b = mul_m(b, b, p);
            r = mul_m(r, b, p);
            c = mul_m(b, b, p);
            a = mul_m(a, c, p);
            m = i;
        end
        if (mul_m(r, r, p) != n) begin
            res.status = ST_NONRES;
            return res;
        end
        res.root = r[ROOT_W-1:0];
        return res;
    endfunction

    function automatic bit is_prime(input int unsigned x);
        if (x < 2) return 0;
        for (int unsigned d = 2; d * d <= x; d++)
            if (x % d == 0) return 0;
        return 1;
    endfunction

    // record every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready)
            pending_roots.push_back(predict_root(req_if.modulus, req_if.value));
    end

    // check every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        sqrt_result_t exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_roots.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result root=%0d status=%0d",
                             res_if.root, res_if.status);
            end else begin
                exp_res = pending_roots.pop_front();
                checked_cnt++;
                if (res_if.root !== exp_res.root || res_if.status !== exp_res.status) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected root=%0d status=%0d, got root=%0d status=%0d",
                                 exp_res.root, exp_res.status, res_if.root, res_if.status);
                end
            end
        end
    end

    // result side ready, with random stalls and a long hold-off on demand
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_req && hold_left == 0) begin
            hold_left <= 60000;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_if.ready <= (hold_left == 1);
        end else begin
            res_if.ready <= !(idle_en && $urandom_range(99) < 12);
        end
    end

    // send one request, idling at random before it
    task automatic send_request(input logic [IN_W-1:0] modulus, input logic [IN_W-1:0] value);
        while (idle_en && $urandom_range(99) < 12) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.modulus <= modulus;
        req_if.value   <= value;
        do @(posedge i_clk); while (!req_if.ready);
        sent_cnt++;
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        wait (pending_roots.size() == 0);
        @(posedge i_clk);
    endtask

    // extremes, bad moduli, zero values, small and large primes, small composites
    task automatic test_directed();
        send_request(32'd0, 32'd5);
        send_request(32'd1, 32'hFFFFFFFF);
        send_request(32'd2, 32'd1);
        send_request(32'hFFFFFFFE, 32'd9);
        send_request(32'hFFFFFFFF, 32'd0);
        send_request(32'd4294967291, 32'hFFFFFFFF);
        send_request(32'd4294967291, 32'd4294967291);
        send_request(32'd3, 32'd1);
        send_request(32'd3, 32'd2);
        send_request(32'd7, 32'd2);
        send_request(32'd7, 32'd0);
        send_request(32'd17, 32'd13);
        send_request(32'd998244353, 32'd7);
        send_request(32'd998244353, 32'd49);
        send_request(32'd1000000007, 32'd123456789);
        send_request(32'd2147483647, 32'd2);
        send_request(32'd3221225473, 32'd2);
        send_request(32'd3221225473, 32'd5);
        send_request(32'd15, 32'd4);
        send_request(32'd9, 32'd7);
        send_request(32'd21, 32'd1);
        send_request(32'd65537, 32'd3);
        wait_drained();
    endtask

    // one random request, mostly primes with residues or random values
    task automatic send_random_request();
        logic [IN_W-1:0] p;
        logic [63:0]     x;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            do p = $urandom_range(65535, 3) | 1; while (!is_prime(p));
        end else if (pick < 80) begin
            p = big_primes[$urandom_range(5)];
        end else if (pick < 92) begin
            p = ($urandom_range(1) != 0) ? ($urandom() & ~32'd1) : $urandom_range(2);
        end else begin
            do p = $urandom_range(99, 9) | 1; while (is_prime(p));
        end
        if ($urandom_range(1) != 0) begin
            x = $urandom();
            send_request(p, IN_W'((p >= 3) ? mul_m(x, x, p) : x));
        end else begin
            send_request(p, $urandom());
        end
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_request();
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (6) send_random_request();
    endtask

    // sender pauses until every result has come, then resumes
    task automatic test_drain_pause();
        test_random(5);
        wait_drained();
        test_random(5);
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.modulus = '0;
        req_if.value = '0;
        mismatch_cnt = 0;
        sent_cnt = 0;
        checked_cnt = 0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(30);
        idle_en = 1'b0;
        test_random(20);
        idle_en = 1'b1;
        test_backpressure();
        test_drain_pause();
        test_random(15);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests: bad moduli, zero values, residues and non-residues,",
                 sent_cnt);
        $display("small and large primes, small composites, stalls; %0d results checked",
                 checked_cnt);
        if (mismatch_cnt == 0 && pending_roots.size() == 0) begin
            $display("PASS modular_square_root");
        end else begin
            $display("FAIL modular_square_root");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/msqrt_pkg.sv
rtl/msqrt_if.sv
rtl/msqrt_mulmod.sv
rtl/modular_square_root.sv
tb/tb_top.sv
